>>> rtl/core/jdw_pkg.sv
// Shared types and constants for the JSON document writer.
// Holds the event codes, byte constants and the run descriptor that passes
// from the front end through the run queue to the byte emitter. No dependencies.
package jdw_pkg;

    // Event codes on the kind input
    localparam logic [2:0] K_OPEN_ARRAY  = 3'd0;
    localparam logic [2:0] K_OPEN_OBJECT = 3'd1;
    localparam logic [2:0] K_CLOSE       = 3'd2;
    localparam logic [2:0] K_NAME        = 3'd3;
    localparam logic [2:0] K_START_TEXT  = 3'd4;
    localparam logic [2:0] K_TEXT        = 3'd5;
    localparam logic [2:0] K_RAW         = 3'd6;
    localparam logic [2:0] K_CLEAR       = 3'd7;

    // Context codes on context_res
    localparam logic [2:0] CTX_NONE         = 3'd0;
    localparam logic [2:0] CTX_ARRAY_VALUE  = 3'd1;
    localparam logic [2:0] CTX_ARRAY_TEXT   = 3'd2;
    localparam logic [2:0] CTX_OBJ_MEMBER   = 3'd3;
    localparam logic [2:0] CTX_OBJ_VALUE    = 3'd4;
    localparam logic [2:0] CTX_OBJ_TEXT     = 3'd5;

    // Characters
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LC_A    = 8'h61;
    localparam logic [7:0] CH_LC_B    = 8'h62;
    localparam logic [7:0] CH_LC_F    = 8'h66;
    localparam logic [7:0] CH_LC_N    = 8'h6E;
    localparam logic [7:0] CH_LC_R    = 8'h72;
    localparam logic [7:0] CH_LC_T    = 8'h74;
    localparam logic [7:0] CH_LC_U    = 8'h75;

    // Byte slots of one run, emitted lowest first
    localparam int NSLOT = 12;
    localparam logic [3:0] SL_COMMA   = 4'd0;
    localparam logic [3:0] SL_NL_PRE  = 4'd1;
    localparam logic [3:0] SL_LEAD    = 4'd2;
    localparam logic [3:0] SL_D0      = 4'd3;  // data byte or backslash
    localparam logic [3:0] SL_D1      = 4'd4;  // escape letter or 'u'
    localparam logic [3:0] SL_D2      = 4'd5;
    localparam logic [3:0] SL_D3      = 4'd6;
    localparam logic [3:0] SL_D4      = 4'd7;
    localparam logic [3:0] SL_D5      = 4'd8;
    localparam logic [3:0] SL_QUOTE   = 4'd9;
    localparam logic [3:0] SL_COLON   = 4'd10;
    localparam logic [3:0] SL_NL_POST = 4'd11;

    localparam int QDEPTH = 4;

    typedef struct packed {
        logic [NSLOT-1:0] mask;
        logic [7:0]       lead;
        logic [7:0]       data;
        logic [7:0]       esc;
        logic             failed;
        logic             done;
        logic [2:0]       ctx;
    } jdw_run_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        if (n < 4'd10)
            hex_digit = CH_ZERO + {4'd0, n};
        else
            hex_digit = CH_LC_A + {4'd0, n} - 8'd10;
    endfunction

endpackage

>>> rtl/core/json_document_writer.sv
// Top level of the JSON document writer.
// Instantiates jdw_front, jdw_queue and jdw_back; depends on jdw_pkg.
//
// Usage:
//   Events enter through a queue-style port: an event is taken on a clock
//   edge with push high and full low. Document bytes leave the same way:
//   while empty is low the oldest byte is on out_byte with its status
//   (last_of_run, failed, doc_done, context_res); pop takes it.
//   Each event yields zero to eleven bytes. The front end classifies one
//   event per cycle while full is low and posts a run descriptor to a
//   four-deep queue; the emitter sends one byte per cycle from the head
//   run while pop is high. Plain string bytes therefore sustain one event
//   per cycle; separators and escapes add bytes to a run, and full rises
//   once the queue fills. An event's run passes through a queue slot and
//   the head register before its first byte reaches the result ports.
//   A failing event gives one status byte (0, failed set); the writer stays
//   failed until a clear event, which gives no bytes.
//   Nesting deeper than MAX_DEPTH fails. Reset returns to the start of an
//   empty document; the stack needs no clearing. A stalled receiver only
//   holds the current byte; events keep entering until the queue is full.
module json_document_writer
    import jdw_pkg::*;
#(
    parameter int MAX_DEPTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] kind,
    input  logic [7:0] data_byte,
    input  logic       has_byte,
    input  logic       first_of_string,
    input  logic       last_of_string,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       failed,
    output logic       doc_done,
    output logic [2:0] context_res
);

    logic     accept;
    logic     run_valid;
    jdw_run_t run;
    jdw_run_t q_dout;
    logic     q_empty;
    logic     q_pop;

    assign accept = push && !full;

    jdw_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .kind            (kind),
        .data_byte       (data_byte),
        .has_byte        (has_byte),
        .first_of_string (first_of_string),
        .last_of_string  (last_of_string),
        .run_valid       (run_valid),
        .run             (run)
    );

    jdw_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (run_valid),
        .din   (run),
        .full  (full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    jdw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_dout      (q_dout),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .failed      (failed),
        .doc_done    (doc_done),
        .context_res (context_res)
    );

endmodule

>>> rtl/core/jdw_front.sv
// Front end of the JSON document writer: classifies each event, keeps the
// writer mode, string state and nesting stack, and builds one run descriptor.
// Depends on jdw_pkg.
module jdw_front
    import jdw_pkg::*;
#(
    parameter int MAX_DEPTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [2:0] kind,
    input  logic [7:0] data_byte,
    input  logic       has_byte,
    input  logic       first_of_string,
    input  logic       last_of_string,
    output logic       run_valid,
    output jdw_run_t   run
);

    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int AW = $clog2(MAX_DEPTH);

    typedef enum logic [3:0] {
        M_FAIL,
        M_FIRST_VALUE,
        M_VALUE,
        M_VALUE_TEXT,
        M_FIRST_MEMBER,
        M_MEMBER,
        M_MEMBER_VALUE,
        M_MEMBER_VALUE_TEXT,
        M_DOC_END
    } mode_t;

    mode_t          mode_reg, mode_next;
    logic [LW-1:0]  level_reg, level_next, level_upd, level_m2;
    logic           sopen_reg, sopen_next;
    logic [2:0]     skind_reg, skind_next;
    logic [1:0]     sclose_reg, sclose_next;
    logic           below_reg;
    logic           kinds_mem [MAX_DEPTH];
    logic           push_we;
    logic [AW-1:0]  rd_addr;

    function automatic logic [2:0] ctx_of(input mode_t m);
        case (m)
            M_FIRST_VALUE, M_VALUE: ctx_of = CTX_ARRAY_VALUE;
            M_VALUE_TEXT:           ctx_of = CTX_ARRAY_TEXT;
            M_FIRST_MEMBER,
            M_MEMBER:               ctx_of = CTX_OBJ_MEMBER;
            M_MEMBER_VALUE:         ctx_of = CTX_OBJ_VALUE;
            M_MEMBER_VALUE_TEXT:    ctx_of = CTX_OBJ_TEXT;
            default:                ctx_of = CTX_NONE;
        endcase
    endfunction

    always_comb
    begin
        logic             fail;
        logic             quoted;
        logic [1:0]       sclose_v;
        logic [NSLOT-1:0] mask;
        logic [7:0]       lead;
        logic [7:0]       esc;

        mode_next   = mode_reg;
        level_next  = level_reg;
        sopen_next  = sopen_reg;
        skind_next  = skind_reg;
        sclose_next = sclose_reg;
        sclose_v    = sclose_reg;
        fail        = 1'b0;
        quoted      = 1'b0;
        mask        = '0;
        lead        = CH_NUL;
        esc         = CH_NUL;
        push_we     = 1'b0;

        if (kind == K_CLEAR)
        begin
            mode_next   = M_FIRST_VALUE;
            level_next  = '0;
            sopen_next  = 1'b0;
            skind_next  = 3'd0;
            sclose_next = 2'd0;
        end
        else if (mode_reg == M_FAIL)
        begin
            fail = 1'b1;
        end
        else if (kind == K_NAME || kind == K_TEXT || kind == K_RAW)
        begin
            if (first_of_string)
            begin
                if (kind == K_NAME)
                begin
                    if (mode_reg == M_MEMBER)
                    begin
                        mask[SL_COMMA]  = 1'b1;
                        mask[SL_NL_PRE] = 1'b1;
                    end
                    else if (mode_reg != M_FIRST_MEMBER)
                        fail = 1'b1;
                    mode_next     = M_MEMBER_VALUE;
                    mask[SL_LEAD] = 1'b1;
                    lead          = CH_QUOTE;
                    sclose_v      = 2'd2;
                end
                else
                begin
                    quoted = (kind == K_TEXT);
                    case (mode_reg)
                        M_VALUE:
                        begin
                            mask[SL_COMMA]  = 1'b1;
                            mask[SL_NL_PRE] = 1'b1;
                        end
                        M_FIRST_VALUE:       mode_next = M_VALUE;
                        M_MEMBER_VALUE:      mode_next = M_MEMBER;
                        M_VALUE_TEXT,
                        M_MEMBER_VALUE_TEXT: quoted = 1'b0;
                        default:             fail = 1'b1;
                    endcase
                    if (quoted)
                    begin
                        mask[SL_LEAD] = 1'b1;
                        lead          = CH_QUOTE;
                    end
                    sclose_v = {1'b0, quoted};
                end
                sopen_next = 1'b1;
                skind_next = kind;
            end
            else if (!sopen_reg || skind_reg != kind)
                fail = 1'b1;

            if (has_byte)
            begin
                mask[SL_D0] = 1'b1;
                if (kind != K_RAW)
                begin
                    if (data_byte == CH_QUOTE || data_byte == CH_BSLASH)
                    begin
                        mask[SL_D1] = 1'b1;
                        esc         = data_byte;
                    end
                    else if (data_byte < 8'd32)
                    begin
                        mask[SL_D1] = 1'b1;
                        case (data_byte)
                            8'd8:    esc = CH_LC_B;
                            8'd9:    esc = CH_LC_T;
                            8'd10:   esc = CH_LC_N;
                            8'd12:   esc = CH_LC_F;
                            8'd13:   esc = CH_LC_R;
                            default:
                            begin
                                esc            = CH_LC_U;
                                mask[SL_D5:SL_D2] = '1;
                            end
                        endcase
                    end
                    else if (data_byte inside {8'hC0, 8'hC1, [8'hF5:8'hFF]})
                        fail = 1'b1;
                end
            end

            if (last_of_string)
            begin
                if (sclose_v != 2'd0)
                    mask[SL_QUOTE] = 1'b1;
                if (sclose_v == 2'd2)
                    mask[SL_COLON] = 1'b1;
                sopen_next = 1'b0;
            end
            sclose_next = sclose_v;
        end
        else if (sopen_reg)
        begin
            fail = 1'b1;
        end
        else if (kind == K_OPEN_ARRAY || kind == K_OPEN_OBJECT)
        begin
            if (!(mode_reg == M_VALUE || mode_reg == M_FIRST_VALUE ||
                  mode_reg == M_MEMBER_VALUE))
                fail = 1'b1;
            if (level_reg >= LW'(MAX_DEPTH))
                fail = 1'b1;
            if (mode_reg == M_VALUE)
            begin
                mask[SL_COMMA]  = 1'b1;
                mask[SL_NL_PRE] = 1'b1;
            end
            mask[SL_LEAD] = 1'b1;
            lead          = (kind == K_OPEN_OBJECT) ? CH_LBRACE : CH_LBRACK;
            push_we       = 1'b1;
            level_next    = level_reg + LW'(1);
            mode_next     = (kind == K_OPEN_OBJECT) ? M_FIRST_MEMBER : M_FIRST_VALUE;
        end
        else if (kind == K_CLOSE)
        begin
            if (level_reg == '0)
                fail = 1'b1;
            mask[SL_LEAD] = 1'b1;
            case (mode_reg)
                M_FIRST_VALUE:  lead = CH_RBRACK;
                M_VALUE:
                begin
                    mask[SL_NL_PRE] = 1'b1;
                    lead            = CH_RBRACK;
                end
                M_FIRST_MEMBER: lead = CH_RBRACE;
                M_MEMBER:
                begin
                    mask[SL_NL_PRE] = 1'b1;
                    lead            = CH_RBRACE;
                end
                M_VALUE_TEXT, M_MEMBER_VALUE_TEXT:
                    lead = CH_QUOTE;
                default:        fail = 1'b1;
            endcase
            if (mode_reg == M_VALUE_TEXT)
                mode_next = M_VALUE;
            else if (mode_reg == M_MEMBER_VALUE_TEXT)
                mode_next = M_MEMBER_VALUE;
            else
            begin
                level_next = level_reg - LW'(1);
                if (level_reg == LW'(1))
                begin
                    mask[SL_NL_POST] = 1'b1;
                    mode_next        = M_DOC_END;
                end
                else
                    mode_next = below_reg ? M_MEMBER : M_VALUE;
            end
        end
        else
        begin
            // start of a text value
            case (mode_reg)
                M_VALUE:
                begin
                    mask[SL_COMMA]  = 1'b1;
                    mask[SL_NL_PRE] = 1'b1;
                    mode_next       = M_VALUE_TEXT;
                end
                M_FIRST_VALUE:  mode_next = M_VALUE_TEXT;
                M_MEMBER_VALUE: mode_next = M_MEMBER_VALUE_TEXT;
                default:        fail = 1'b1;
            endcase
            mask[SL_LEAD] = 1'b1;
            lead          = CH_QUOTE;
        end

        if (fail)
        begin
            // failing transaction: single status byte, everything else dropped
            mode_next   = M_FAIL;
            level_next  = level_reg;
            push_we     = 1'b0;
            run.mask    = '0;
            run.mask[SL_LEAD] = 1'b1;
            run.lead    = CH_NUL;
            run.failed  = 1'b1;
            run.done    = 1'b0;
            run.ctx     = CTX_NONE;
        end
        else
        begin
            run.mask    = mask;
            run.lead    = lead;
            run.failed  = 1'b0;
            run.done    = (mode_next == M_DOC_END);
            run.ctx     = ctx_of(mode_next);
        end
        run.data  = data_byte;
        run.esc   = esc;
        run_valid = accept && (kind != K_CLEAR) && (fail || (mask != '0));
    end

    assign level_upd = accept ? level_next : level_reg;
    assign level_m2  = level_upd - LW'(2);
    assign rd_addr   = level_m2[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_FIRST_VALUE;
            level_reg  <= '0;
            sopen_reg  <= 1'b0;
            skind_reg  <= 3'd0;
            sclose_reg <= 2'd0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            level_reg  <= level_next;
            sopen_reg  <= sopen_next;
            skind_reg  <= skind_next;
            sclose_reg <= sclose_next;
        end
    end

    // Nesting stack; below_reg tracks the entry under the top of stack
    always_ff @(posedge clk)
    begin
        if (accept && push_we)
            kinds_mem[level_reg[AW-1:0]] <= (kind == K_OPEN_OBJECT);
        below_reg <= kinds_mem[rd_addr];
    end

endmodule

>>> rtl/core/jdw_queue.sv
// Short run queue between the front end and the byte emitter.
// Holds jdw_run_t descriptors; depth QDEPTH from jdw_pkg.
module jdw_queue
    import jdw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  jdw_run_t din,
    output logic     full,
    input  logic     pop,
    output jdw_run_t dout,
    output logic     empty
);

    localparam int PW = $clog2(QDEPTH);

    jdw_run_t          slots_reg [QDEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]       count_reg;
    logic              do_push, do_pop;

    assign full    = (count_reg == (PW+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (PW+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= din;
    end

endmodule

>>> rtl/core/jdw_back.sv
// Byte emitter of the JSON document writer: expands the run at the head of
// the queue into document bytes, one per pop. Depends on jdw_pkg.
module jdw_back
    import jdw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  jdw_run_t   q_dout,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       failed,
    output logic       doc_done,
    output logic [2:0] context_res
);

    jdw_run_t         head_reg;
    logic             head_valid_reg;
    logic [NSLOT-1:0] low_bit;
    logic [3:0]       slot;
    logic             take, drained, load;

    assign low_bit     = head_reg.mask & (~head_reg.mask + NSLOT'(1));
    assign last_of_run = (head_reg.mask & (head_reg.mask - NSLOT'(1))) == '0;
    assign empty       = !head_valid_reg;
    assign take        = pop && head_valid_reg;
    assign drained     = take && last_of_run;
    assign load        = (!head_valid_reg || drained) && !q_empty;
    assign q_pop       = load;
    assign failed      = head_reg.failed;
    assign doc_done    = head_reg.done;
    assign context_res = head_reg.ctx;

    always_comb
    begin
        slot = SL_COMMA;
        for (int i = NSLOT - 1; i >= 0; i--)
        begin
            if (head_reg.mask[i])
                slot = 4'(i);
        end
    end

    always_comb
    begin
        case (slot)
            SL_COMMA:   out_byte = CH_COMMA;
            SL_NL_PRE:  out_byte = CH_NL;
            SL_LEAD:    out_byte = head_reg.lead;
            SL_D0:      out_byte = head_reg.mask[SL_D1] ? CH_BSLASH : head_reg.data;
            SL_D1:      out_byte = head_reg.esc;
            SL_D2:      out_byte = CH_ZERO;
            SL_D3:      out_byte = CH_ZERO;
            SL_D4:      out_byte = hex_digit(head_reg.data[7:4]);
            SL_D5:      out_byte = hex_digit(head_reg.data[3:0]);
            SL_QUOTE:   out_byte = CH_QUOTE;
            SL_COLON:   out_byte = CH_COLON;
            SL_NL_POST: out_byte = CH_NL;
            default:    out_byte = CH_NUL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            head_valid_reg <= 1'b0;
        else if (load)
            head_valid_reg <= 1'b1;
        else if (drained)
            head_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            head_reg <= q_dout;
        else if (take)
            head_reg.mask <= head_reg.mask & ~low_bit;
    end

endmodule

>>> rtl/core/jdw_checker.sv
// Port-level checks for the JSON document writer, bound to the top level.
// Sees only the ports of json_document_writer; takes the codes from jdw_pkg.
module jdw_checker
    import jdw_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       last_of_run,
    input logic       failed,
    input logic       doc_done,
    input logic [2:0] context_res
);

    // a failure is reported as one zero status byte
    a_fail_status: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && failed |-> last_of_run && out_byte == CH_NUL && !doc_done &&
                             context_res == CTX_NONE)
        else $error("failure status byte malformed");

    // a finished document has no open context
    a_done_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && doc_done |-> context_res == CTX_NONE && !failed)
        else $error("document done with open context");

    a_ctx_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> context_res <= CTX_OBJ_TEXT)
        else $error("context code out of range");

    // a stalled transaction holds its byte
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_byte) && $stable(last_of_run))
        else $error("waiting result changed while stalled");

endmodule

bind json_document_writer jdw_checker u_jdw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .failed      (failed),
    .doc_done    (doc_done),
    .context_res (context_res)
);

>>> tb/testbench.sv
// Self-checking testbench for json_document_writer: drives writer events through the push
// side, predicts the document bytes with its own writer model and checks every popped byte.
// Depends on jdw_pkg and the json_document_writer RTL.
`timescale 1ns / 100ps

module testbench;
    import jdw_pkg::*;

    localparam int NEST_LIMIT      = 64;
    localparam int TOTAL_ITEMS     = 210;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 20;

    typedef enum logic [3:0] {
        WM_FAILED,
        WM_FIRST_VALUE,
        WM_VALUE,
        WM_VALUE_TEXT,
        WM_FIRST_MEMBER,
        WM_MEMBER,
        WM_MEMBER_VALUE,
        WM_MEMBER_VALUE_TEXT,
        WM_DOC_END
    } writer_mode_e;

    typedef enum logic [1:0] {SC_NONE, SC_QUOTE, SC_QUOTE_COLON} string_close_e;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       has;
        logic       first;
        logic       last;
    } doc_event_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       failed;
        logic       done;
        logic [2:0] ctx;
    } doc_byte_t;

    // Writer model plus the queue of document bytes still to come out of the block
    class doc_text_scoreboard;
        writer_mode_e  mode;
        bit            nest_is_obj [NEST_LIMIT];
        int            level;
        bit            str_open;
        logic [2:0]    str_kind;
        string_close_e str_close;
        logic [7:0]    run_bytes [$];
        doc_byte_t     expected_bytes [$];
        int            mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            mode      = WM_FIRST_VALUE;
            level     = 0;
            str_open  = 1'b0;
            str_kind  = K_OPEN_ARRAY;
            str_close = SC_NONE;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void emit(logic [7:0] c);
            if (run_bytes.size() < 16)
                run_bytes.insert(run_bytes.size(), c);
        endfunction

        function void emit_sep();
            emit(CH_COMMA);
            emit(CH_NL);
        endfunction

        function void emit_escaped(logic [7:0] b);
            string digits;
            digits = "0123456789abcdef";
            if (b == 8'hC0 || b == 8'hC1 || b >= 8'hF5)
            begin
                mode = WM_FAILED;
                return;
            end
            if (b >= 8'h20 && b != CH_QUOTE && b != CH_BSLASH)
            begin
                emit(b);
                return;
            end
            emit(CH_BSLASH);
            case (b)
                CH_QUOTE:  emit(CH_QUOTE);
                CH_BSLASH: emit(CH_BSLASH);
                8'h08:     emit(CH_LC_B);
                8'h09:     emit(CH_LC_T);
                CH_NL:     emit(CH_LC_N);
                8'h0C:     emit(CH_LC_F);
                8'h0D:     emit(CH_LC_R);
                default:
                begin
                    emit(CH_LC_U);
                    emit(CH_ZERO);
                    emit(CH_ZERO);
                    emit(8'(digits[b[7:4]]));
                    emit(8'(digits[b[3:0]]));
                end
            endcase
        endfunction

        function void open_container(bit is_obj);
            if (mode != WM_VALUE && mode != WM_FIRST_VALUE && mode != WM_MEMBER_VALUE)
            begin
                mode = WM_FAILED;
                return;
            end
            if (level >= NEST_LIMIT)
            begin
                mode = WM_FAILED;
                return;
            end
            if (mode == WM_VALUE)
                emit_sep();
            emit(is_obj ? CH_LBRACE : CH_LBRACK);
            nest_is_obj[level] = is_obj;
            level++;
            mode = is_obj ? WM_FIRST_MEMBER : WM_FIRST_VALUE;
        endfunction

        function void close_container();
            if (level == 0)
            begin
                mode = WM_FAILED;
                return;
            end
            case (mode)
                WM_FIRST_VALUE:  emit(CH_RBRACK);
                WM_VALUE:
                begin
                    emit(CH_NL);
                    emit(CH_RBRACK);
                end
                WM_FIRST_MEMBER: emit(CH_RBRACE);
                WM_MEMBER:
                begin
                    emit(CH_NL);
                    emit(CH_RBRACE);
                end
                // close inside a text value only ends the text
                WM_VALUE_TEXT:
                begin
                    emit(CH_QUOTE);
                    mode = WM_VALUE;
                    return;
                end
                WM_MEMBER_VALUE_TEXT:
                begin
                    emit(CH_QUOTE);
                    mode = WM_MEMBER_VALUE;
                    return;
                end
                default:
                begin
                    mode = WM_FAILED;
                    return;
                end
            endcase
            level--;
            if (level == 0)
            begin
                emit(CH_NL);
                mode = WM_DOC_END;
            end
            else
                mode = nest_is_obj[level - 1] ? WM_MEMBER : WM_VALUE;
        endfunction

        function void start_text();
            case (mode)
                WM_VALUE:
                begin
                    emit_sep();
                    mode = WM_VALUE_TEXT;
                end
                WM_FIRST_VALUE:  mode = WM_VALUE_TEXT;
                WM_MEMBER_VALUE: mode = WM_MEMBER_VALUE_TEXT;
                default:
                begin
                    mode = WM_FAILED;
                    return;
                end
            endcase
            emit(CH_QUOTE);
        endfunction

        function void open_string(logic [2:0] k);
            bit quoted;
            quoted = (k == K_TEXT);
            if (k == K_NAME)
            begin
                if (mode == WM_MEMBER)
                    emit_sep();
                else if (mode != WM_FIRST_MEMBER)
                begin
                    mode = WM_FAILED;
                    return;
                end
                mode = WM_MEMBER_VALUE;
                emit(CH_QUOTE);
                str_close = SC_QUOTE_COLON;
            end
            else
            begin
                case (mode)
                    WM_VALUE:                            emit_sep();
                    WM_FIRST_VALUE:                      mode = WM_VALUE;
                    WM_MEMBER_VALUE:                     mode = WM_MEMBER;
                    WM_VALUE_TEXT, WM_MEMBER_VALUE_TEXT: quoted = 1'b0;
                    default:
                    begin
                        mode = WM_FAILED;
                        return;
                    end
                endcase
                if (quoted)
                    emit(CH_QUOTE);
                str_close = quoted ? SC_QUOTE : SC_NONE;
            end
            str_open = 1'b1;
            str_kind = k;
        endfunction

        function void string_item(doc_event_t ev);
            if (ev.first)
            begin
                open_string(ev.kind);
                if (mode == WM_FAILED)
                    return;
            end
            else if (!str_open || str_kind != ev.kind)
            begin
                mode = WM_FAILED;
                return;
            end
            if (ev.has)
            begin
                if (ev.kind == K_RAW)
                    emit(ev.data);
                else
                    emit_escaped(ev.data);
                if (mode == WM_FAILED)
                    return;
            end
            if (ev.last)
            begin
                if (str_close != SC_NONE)
                    emit(CH_QUOTE);
                if (str_close == SC_QUOTE_COLON)
                    emit(CH_COLON);
                str_open = 1'b0;
            end
        endfunction

        function logic [2:0] context_code();
            case (mode)
                WM_FIRST_VALUE, WM_VALUE:   return CTX_ARRAY_VALUE;
                WM_VALUE_TEXT:              return CTX_ARRAY_TEXT;
                WM_FIRST_MEMBER, WM_MEMBER: return CTX_OBJ_MEMBER;
                WM_MEMBER_VALUE:            return CTX_OBJ_VALUE;
                WM_MEMBER_VALUE_TEXT:       return CTX_OBJ_TEXT;
                default:                    return CTX_NONE;
            endcase
        endfunction

        // Accepted event: advance the model and queue the bytes it produces
        function void note_event(doc_event_t ev);
            doc_byte_t  want;
            logic [2:0] ctx;
            logic       done;
            run_bytes.delete();
            if (ev.kind == K_CLEAR)
            begin
                restart();
                return;
            end
            if (mode != WM_FAILED)
            begin
                if (ev.kind == K_NAME || ev.kind == K_TEXT || ev.kind == K_RAW)
                    string_item(ev);
                else if (str_open)
                    mode = WM_FAILED;
                else if (ev.kind == K_OPEN_ARRAY || ev.kind == K_OPEN_OBJECT)
                    open_container(ev.kind == K_OPEN_OBJECT);
                else if (ev.kind == K_CLOSE)
                    close_container();
                else
                    start_text();
            end
            if (mode == WM_FAILED)
            begin
                // failed writer: one status byte replaces whatever would have come out
                want = '{CH_NUL, 1'b1, 1'b1, 1'b0, CTX_NONE};
                expected_bytes.insert(expected_bytes.size(), want);
                return;
            end
            ctx  = context_code();
            done = (mode == WM_DOC_END);
            foreach (run_bytes[i])
            begin
                want = '{run_bytes[i], i == run_bytes.size() - 1, 1'b0, done, ctx};
                expected_bytes.insert(expected_bytes.size(), want);
            end
        endfunction

        function void check_byte(doc_byte_t got);
            doc_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output byte %02h last %0b failed %0b done %0b ctx %0d",
                             got.ch, got.last, got.failed, got.done, got.ctx);
                return;
            end
            want = expected_bytes.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %02h %0b %0b %0b %0d got %02h %0b %0b %0b %0d",
                             want.ch, want.last, want.failed, want.done, want.ctx,
                             got.ch, got.last, got.failed, got.done, got.ctx);
            end
        endfunction
    endclass

    logic       clk             = 1'b0;
    logic       rst_n           = 1'b0;
    logic       push            = 1'b0;
    logic [2:0] kind            = K_OPEN_ARRAY;
    logic [7:0] data_byte       = 8'h00;
    logic       has_byte        = 1'b0;
    logic       first_of_string = 1'b0;
    logic       last_of_string  = 1'b0;
    logic       pop             = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       failed;
    logic       doc_done;
    logic [2:0] context_res;

    doc_text_scoreboard sb = new();
    int burst_left   = 0;
    int events_sent  = 0;
    bit hold_off_req = 1'b0;

    json_document_writer #(
        .MAX_DEPTH(NEST_LIMIT)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .kind            (kind),
        .data_byte       (data_byte),
        .has_byte        (has_byte),
        .first_of_string (first_of_string),
        .last_of_string  (last_of_string),
        .empty           (empty),
        .pop             (pop),
        .out_byte        (out_byte),
        .last_of_run     (last_of_run),
        .failed          (failed),
        .doc_done        (doc_done),
        .context_res     (context_res)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Entered and left at a falling edge; the sender idles between bursts
    task automatic send_event(input logic [2:0] k, input logic [7:0] d,
                              input logic h, input logic f, input logic l);
        doc_event_t ev;
        ev = '{k, d, h, f, l};
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
        end
        push            <= 1'b1;
        kind            <= k;
        data_byte       <= d;
        has_byte        <= h;
        first_of_string <= f;
        last_of_string  <= l;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_event(ev);
        events_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_noise();
        send_event(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                   1'($urandom), 1'($urandom));
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_string_byte();
        logic [7:0] pick;
        case ($urandom_range(0, 19))
            0, 1: pick = 8'($urandom_range(0, 31));
            2:    pick = CH_QUOTE;
            3:    pick = CH_BSLASH;
            4:
            begin
                if ($urandom_range(0, 2) == 0)
                    pick = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'hC0, 8'hC1))
                                                       : 8'($urandom_range(8'hF5, 8'hFF));
                else
                    pick = 8'($urandom_range(128, 244));
            end
            default: pick = 8'($urandom_range(32, 126));
        endcase
        return pick;
    endfunction

    task automatic send_random_string(input logic [2:0] k);
        int len;
        int i;
        len = $urandom_range(0, 5);
        if (len == 0)
        begin
            send_event(k, 8'($urandom), 1'b0, 1'b1, 1'b1);
            return;
        end
        for (i = 0; i < len; i++)
        begin
            // empty piece with no marks inside an open string
            if (i > 0 && $urandom_range(0, 9) == 0)
                send_event(k, 8'($urandom), 1'b0, 1'b0, 1'b0);
            send_event(k, pick_string_byte(), 1'b1, i == 0, i == len - 1);
        end
    endtask

    // Well-formed document with random content, now and then broken by a noise transaction
    task automatic send_random_document(input int budget, input int depth_cap);
        bit nest [$];
        bit need_value;
        bit is_obj;
        int choice;
        int pieces;
        is_obj = 1'($urandom);
        send_event(is_obj ? K_OPEN_OBJECT : K_OPEN_ARRAY, 8'($urandom), 1'b0, 1'b0, 1'b0);
        nest.insert(nest.size(), is_obj);
        need_value = 1'b0;
        while (nest.size() > 0)
        begin
            if (!need_value && (budget <= 0 || $urandom_range(0, 4) == 0))
            begin
                send_event(K_CLOSE, 8'($urandom), 1'b0, 1'b0, 1'b0);
                nest.delete(nest.size() - 1);
            end
            else if (nest[$] && !need_value)
            begin
                send_random_string(K_NAME);
                need_value = 1'b1;
            end
            else
            begin
                choice = $urandom_range(0, 5);
                if (choice <= 1 && nest.size() < depth_cap)
                begin
                    is_obj = 1'($urandom);
                    send_event(is_obj ? K_OPEN_OBJECT : K_OPEN_ARRAY, 8'($urandom),
                               1'b0, 1'b0, 1'b0);
                    nest.insert(nest.size(), is_obj);
                end
                else if (choice == 2)
                begin
                    send_event(K_START_TEXT, 8'($urandom), 1'b0, 1'b0, 1'b0);
                    pieces = $urandom_range(1, 2);
                    repeat (pieces)
                        send_random_string(K_TEXT);
                    send_event(K_CLOSE, 8'($urandom), 1'b0, 1'b0, 1'b0);
                end
                else if (choice == 3)
                    send_random_string(K_RAW);
                else
                    send_random_string(K_TEXT);
                need_value = 1'b0;
            end
            if ($urandom_range(0, 39) == 0)
                send_noise();
            budget--;
        end
    endtask

    // Fill the stack to the depth limit, step back into an object level, refill and overflow
    task automatic send_deep_nest();
        int i;
        bit is_obj;
        for (i = 0; i < NEST_LIMIT; i++)
        begin
            is_obj = (i == NEST_LIMIT - 2) ||
                     (i < NEST_LIMIT - 2 && $urandom_range(0, 7) == 0);
            send_event(is_obj ? K_OPEN_OBJECT : K_OPEN_ARRAY, 8'h00, 1'b0, 1'b0, 1'b0);
            if (is_obj)
                send_event(K_NAME, 8'h6B, 1'b1, 1'b1, 1'b1);
        end
        send_event(K_CLOSE, 8'h00, 1'b0, 1'b0, 1'b0);
        send_event(K_NAME, 8'h6B, 1'b1, 1'b1, 1'b1);
        send_event(K_OPEN_ARRAY, 8'h00, 1'b0, 1'b0, 1'b0);
        send_event(K_OPEN_ARRAY, 8'h00, 1'b0, 1'b0, 1'b0);
        send_event(K_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0);
    endtask

    // Result side: take a transaction whenever pop meets a non-empty queue
    always @(posedge clk)
    begin
        doc_byte_t got;
        if (rst_n && pop && !empty)
        begin
            got = '{out_byte, last_of_run, failed, doc_done, context_res};
            sb.check_byte(got);
        end
    end

    // Receiver stalls follow a random 16-bit pop pattern, redrawn each time its slot index wraps
    initial
    begin
        logic [15:0] pattern;
        int          slot;
        pattern = 16'hFFFF;
        slot    = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                if (slot == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       pattern = 16'hFFFF;
                        1:       pattern = 16'($urandom | $urandom);
                        2:       pattern = 16'($urandom);
                        default: pattern = 16'($urandom & $urandom);
                    endcase
                end
                pop <= pattern[slot];
                slot = (slot + 1) % 16;
            end
        end
    end

    initial
    begin
        #6_000_000;
        $display("[json_document_writer] ERROR");
        $finish;
    end

    initial
    begin
        int doc_index;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // object whose name and text need every kind of escape
        send_event(K_OPEN_OBJECT, 8'h00, 1'b0, 1'b0, 1'b0);
        send_event(K_NAME, 8'h00, 1'b1, 1'b1, 1'b0);
        send_event(K_NAME, 8'h08, 1'b1, 1'b0, 1'b0);
        send_event(K_NAME, CH_QUOTE, 1'b1, 1'b0, 1'b0);
        send_event(K_NAME, CH_BSLASH, 1'b1, 1'b0, 1'b1);
        send_event(K_START_TEXT, 8'hFF, 1'b1, 1'b1, 1'b1);
        send_event(K_TEXT, 8'h09, 1'b1, 1'b1, 1'b0);
        send_event(K_TEXT, CH_NL, 1'b1, 1'b0, 1'b0);
        send_event(K_TEXT, 8'h0C, 1'b1, 1'b0, 1'b0);
        send_event(K_TEXT, 8'h0D, 1'b1, 1'b0, 1'b0);
        send_event(K_TEXT, 8'h1F, 1'b1, 1'b0, 1'b0);
        send_event(K_TEXT, 8'hF4, 1'b1, 1'b0, 1'b1);
        send_event(K_CLOSE, 8'h00, 1'b0, 1'b0, 1'b0);
        // raw bytes pass unchecked
        send_event(K_RAW, 8'hFF, 1'b1, 1'b1, 1'b1);
        send_event(K_NAME, 8'h00, 1'b0, 1'b1, 1'b1);
        send_event(K_OPEN_ARRAY, 8'h00, 1'b0, 1'b0, 1'b0);
        send_event(K_TEXT, 8'h41, 1'b1, 1'b1, 1'b1);
        send_event(K_RAW, 8'h31, 1'b1, 1'b1, 1'b1);
        send_event(K_OPEN_ARRAY, 8'h00, 1'b0, 1'b0, 1'b0);
        send_event(K_CLOSE, 8'h00, 1'b0, 1'b0, 1'b0);
        send_event(K_CLOSE, 8'h00, 1'b0, 1'b0, 1'b0);
        send_event(K_CLOSE, 8'h00, 1'b0, 1'b0, 1'b0);
        // anything after the document ends fails, and failure sticks
        send_event(K_RAW, 8'h7F, 1'b1, 1'b1, 1'b1);
        send_event(K_TEXT, 8'h41, 1'b1, 1'b1, 1'b1);
        send_event(K_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0);
        // empty piece mid-string, then an invalid byte
        send_event(K_TEXT, 8'h41, 1'b1, 1'b1, 1'b0);
        send_event(K_TEXT, 8'h55, 1'b0, 1'b0, 1'b0);
        send_event(K_TEXT, 8'hC0, 1'b1, 1'b0, 1'b1);
        send_event(K_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0);
        send_event(K_CLOSE, 8'h00, 1'b0, 1'b0, 1'b0);
        send_event(K_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0);
        // string continued under another kind
        send_event(K_RAW, 8'h78, 1'b1, 1'b1, 1'b0);
        send_event(K_TEXT, 8'h79, 1'b1, 1'b0, 1'b1);
        send_event(K_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0);
        // container opened while a string is still open
        send_event(K_OPEN_ARRAY, 8'h00, 1'b0, 1'b0, 1'b0);
        send_event(K_RAW, 8'h7A, 1'b1, 1'b1, 1'b0);
        send_event(K_OPEN_OBJECT, 8'h00, 1'b0, 1'b0, 1'b0);
        send_event(K_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0);
        send_event(K_NAME, 8'hC1, 1'b1, 1'b1, 1'b1);
        send_event(K_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0);
        wait_drained();

        send_deep_nest();
        wait_drained();

        doc_index = 0;
        while (events_sent < TOTAL_ITEMS)
        begin
            if (doc_index == 0)
                hold_off_req = 1'b1;
            send_random_document(doc_index == 0 ? 40 : $urandom_range(3, 24), 6);
            if ($urandom_range(0, 4) == 0)
                send_noise();
            send_event(K_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
            doc_index++;
        end

        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[json_document_writer] OK");
        else
            $display("[json_document_writer] ERROR");
        $finish;
    end

endmodule
